@@ sv/assert_macros.svh @@
// Assertion macros used by the reassembly queue datapath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset
`define TSRQ_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("tsrq assertion failed");

// Check that a condition implies another in the same cycle
`define TSRQ_ASSERT_IMPLY(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("tsrq assertion failed");

// Check that a condition implies another in the next cycle
`define TSRQ_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("tsrq assertion failed");

`endif

@@ sv/tsrq_pkg.sv @@
// Shared types and codes of the reassembly queue
package tsrq_pkg;

    localparam logic [1:0] ACT_ENQ   = 2'd0;
    localparam logic [1:0] ACT_DEQ   = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [1:0] EV_VERDICT = 2'd0;
    localparam logic [1:0] EV_DELIVER = 2'd1;
    localparam logic [1:0] EV_DROP    = 2'd2;
    localparam logic [1:0] EV_DONE    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_DECIDE,
        ST_DROP,
        ST_DELIVER
    } state_t;

    typedef struct packed {
        logic       load;
        logic       scan;
        logic       pick;
        logic       ins;
        logic       dis;
        logic       pop;
        logic       adv;
        logic       emit;
        logic [1:0] ev;
        logic       acc;
        logic       last;
    } tsrq_cmd_t;

    typedef struct packed {
        logic [1:0] in_action;
        logic       out_free;
        logic       count_zero;
        logic       count_one;
        logic       enabled;
        logic       reject;
        logic       hit_eq;
        logic       len_mismatch;
        logic       overlap;
        logic       head_match;
    } tsrq_stat_t;

endpackage

@@ sv/tcp_segment_reassembly_queue_top.sv @@
// Top level of the TCP segment reassembly queue
// Enqueue: the word is loaded, scanned, picked and decided, and the verdict is registered; a
// disabling enqueue first drops every entry, then registers its verdict.
// Dequeue: one word per delivered entry plus a done word; flush: one drop word per entry.
// One item in work at a time, set by the single insert/scan datapath; next word taken
// the cycle after the last result is registered; a busy output holds each result.
// Synchronous active-low reset empties the queue, enables it and sets the budget to 65535.
module tcp_segment_reassembly_queue_top import tsrq_pkg::*; #(
    parameter int MAX_SEGMENTS = 16,
    parameter int TAG_BITS     = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_seq_number,
    input  logic [15:0] s_segment_length,
    input  logic [7:0]  s_segment_tag,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic        m_accepted,
    output logic [7:0]  m_out_tag,
    output logic [31:0] m_out_seq,
    output logic [31:0] m_next_seq,
    output logic        m_queue_disabled,
    output logic        m_last
);

    tsrq_cmd_t  cmd;
    tsrq_stat_t stat;

    tsrq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tsrq_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .TAG_BITS     (TAG_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_action         (s_action),
        .s_seq_number     (s_seq_number),
        .s_segment_length (s_segment_length),
        .s_segment_tag    (s_segment_tag),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_accepted       (m_accepted),
        .m_out_tag        (m_out_tag),
        .m_out_seq        (m_out_seq),
        .m_next_seq       (m_next_seq),
        .m_queue_disabled (m_queue_disabled),
        .m_last           (m_last),
        .cmd              (cmd),
        .stat             (stat)
    );

endmodule

@@ sv/tsrq_ctrl.sv @@
// Controller state machine of the reassembly queue
module tsrq_ctrl import tsrq_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  tsrq_stat_t stat,
    output tsrq_cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   drop_dis_reg, drop_dis_next;
    logic   head_go;

    assign head_go = stat.enabled && !stat.count_zero && stat.head_match;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            drop_dis_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            drop_dis_reg <= drop_dis_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        drop_dis_next = drop_dis_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (stat.in_action)
                        ACT_ENQ: state_next = ST_SCAN;
                        ACT_DEQ: state_next = ST_DELIVER;
                        ACT_FLUSH: begin
                            state_next    = ST_DROP;
                            drop_dis_next = 1'b0;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: state_next = ST_PICK;
            ST_PICK: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (stat.out_free) begin
                    if (!stat.reject && ((stat.hit_eq && stat.len_mismatch) ||
                                         (!stat.hit_eq && stat.overlap))) begin
                        state_next    = ST_DROP;
                        drop_dis_next = 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DROP: begin
                if (stat.count_zero) begin
                    if (!drop_dis_reg || stat.out_free) state_next = ST_IDLE;
                end else if (stat.out_free && stat.count_one && !drop_dis_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DELIVER: begin
                if (stat.out_free && !head_go) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.ev   = EV_VERDICT;
        s_ready  = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: cmd.load = s_valid;
            ST_SCAN: cmd.scan = 1'b1;
            ST_PICK: cmd.pick = 1'b1;
            ST_DECIDE: begin
                if (stat.out_free) begin
                    if (stat.reject) begin
                        cmd.emit = 1'b1;
                        cmd.last = 1'b1;
                    end else if (stat.hit_eq) begin
                        if (stat.len_mismatch) begin
                            cmd.dis = 1'b1;
                        end else begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                        end
                    end else if (stat.overlap) begin
                        cmd.dis = 1'b1;
                    end else begin
                        cmd.ins  = 1'b1;
                        cmd.emit = 1'b1;
                        cmd.acc  = 1'b1;
                        cmd.last = 1'b1;
                    end
                end
            end
            ST_DROP: begin
                if (stat.out_free) begin
                    if (stat.count_zero) begin
                        if (drop_dis_reg) begin
                            cmd.emit = 1'b1;
                            cmd.last = 1'b1;
                        end
                    end else begin
                        cmd.emit = 1'b1;
                        cmd.ev   = EV_DROP;
                        cmd.pop  = 1'b1;
                        cmd.last = stat.count_one && !drop_dis_reg;
                    end
                end
            end
            ST_DELIVER: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (head_go) begin
                        cmd.ev  = EV_DELIVER;
                        cmd.pop = 1'b1;
                        cmd.adv = 1'b1;
                    end else begin
                        cmd.ev   = EV_DONE;
                        cmd.last = 1'b1;
                    end
                end
            end
            default: cmd = '0;
        endcase
    end

endmodule

@@ sv/tsrq_dp.sv @@
// Datapath of the reassembly queue: sorted table, counters, result register
`include "assert_macros.svh"
module tsrq_dp import tsrq_pkg::*; #(
    parameter int MAX_SEGMENTS = 16,
    parameter int TAG_BITS     = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [1:0]  s_action,
    input  logic [31:0] s_seq_number,
    input  logic [15:0] s_segment_length,
    input  logic [7:0]  s_segment_tag,
    input  logic        cfg_wr_en,
    input  logic [19:0] cfg_wr_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic        m_accepted,
    output logic [7:0]  m_out_tag,
    output logic [31:0] m_out_seq,
    output logic [31:0] m_next_seq,
    output logic        m_queue_disabled,
    output logic        m_last,
    input  tsrq_cmd_t   cmd,
    output tsrq_stat_t  stat
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    logic [31:0]         entry_seq_reg [MAX_SEGMENTS];
    logic [15:0]         entry_len_reg [MAX_SEGMENTS];
    logic [TAG_BITS-1:0] entry_tag_reg [MAX_SEGMENTS];

    logic [CNT_W-1:0]        count_reg;
    logic [19:0]             bytes_reg;
    logic                    enabled_reg;
    logic [19:0]             max_bytes_reg;
    logic [31:0]             seq_in_reg, nxt_reg;
    logic [15:0]             len_in_reg;
    logic [TAG_BITS-1:0]     tag_in_reg;
    logic [MAX_SEGMENTS-1:0] eq_vec_reg, lt_vec_reg;
    logic                    reject_reg;
    logic                    hit_eq_reg, hit_lt_reg;
    logic [CNT_W-1:0]        pos_reg;
    logic [31:0]             sel_seq_reg;
    logic [15:0]             sel_len_reg;

    logic                    m_valid_reg;
    logic [1:0]              m_event_reg;
    logic                    m_acc_reg, m_dis_reg, m_last_reg;
    logic [7:0]              m_tag_reg;
    logic [31:0]             m_seq_reg, m_next_reg;

    logic [MAX_SEGMENTS-1:0] eq_vec_next, lt_vec_next;
    logic [20:0]             bytes_sum;
    logic [CNT_W-1:0]        pos_next;
    logic                    hit_eq_next, hit_lt_next;
    logic [31:0]             seg_end, end_diff;
    logic [15:0]             tag_wide_in, tag_wide_out;
    logic                    out_free;

    assign out_free    = !m_valid_reg || m_ready;
    assign bytes_sum   = {1'b0, bytes_reg} + {5'b0, s_segment_length};
    assign tag_wide_in = 16'(s_segment_tag);
    assign tag_wide_out = 16'(entry_tag_reg[0]);
    assign seg_end     = seq_in_reg + {16'b0, len_in_reg};
    assign end_diff    = seg_end - sel_seq_reg;

    always_comb begin
        logic [31:0] diff;
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            diff           = seq_in_reg - entry_seq_reg[i];
            eq_vec_next[i] = (CNT_W'(i) < count_reg) && (seq_in_reg == entry_seq_reg[i]);
            lt_vec_next[i] = (CNT_W'(i) < count_reg) && diff[31];
        end
    end

    always_comb begin
        pos_next    = count_reg;
        hit_eq_next = 1'b0;
        hit_lt_next = 1'b0;
        for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
            if (eq_vec_reg[i] || lt_vec_reg[i]) begin
                pos_next    = CNT_W'(i);
                hit_eq_next = eq_vec_reg[i];
                hit_lt_next = !eq_vec_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            bytes_reg     <= '0;
            enabled_reg   <= 1'b1;
            max_bytes_reg <= 20'd65535;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) max_bytes_reg <= cfg_wr_data;
            if (cmd.dis) enabled_reg <= 1'b0;
            if (cmd.ins) begin
                count_reg <= count_reg + CNT_W'(1);
                bytes_reg <= bytes_reg + 20'(len_in_reg);
            end else if (cmd.pop) begin
                count_reg <= count_reg - CNT_W'(1);
                bytes_reg <= bytes_reg - 20'(entry_len_reg[0]);
            end
            if (cmd.emit) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            seq_in_reg <= s_seq_number;
            nxt_reg    <= s_seq_number;
            len_in_reg <= s_segment_length;
            tag_in_reg <= tag_wide_in[TAG_BITS-1:0];
            reject_reg <= !enabled_reg || (bytes_sum > {1'b0, max_bytes_reg}) ||
                          (count_reg >= CNT_W'(MAX_SEGMENTS));
        end
        if (cmd.adv) nxt_reg <= nxt_reg + {16'b0, entry_len_reg[0]};
        if (cmd.scan) begin
            eq_vec_reg <= eq_vec_next;
            lt_vec_reg <= lt_vec_next;
        end
        if (cmd.pick) begin
            pos_reg     <= pos_next;
            hit_eq_reg  <= hit_eq_next;
            hit_lt_reg  <= hit_lt_next;
            sel_seq_reg <= entry_seq_reg[pos_next[IDX_W-1:0]];
            sel_len_reg <= entry_len_reg[pos_next[IDX_W-1:0]];
        end
        for (int j = 0; j < MAX_SEGMENTS; j++) begin
            if (cmd.ins) begin
                if (j > 0 && CNT_W'(j) > pos_reg) begin
                    entry_seq_reg[j] <= entry_seq_reg[(j > 0) ? j - 1 : 0];
                    entry_len_reg[j] <= entry_len_reg[(j > 0) ? j - 1 : 0];
                    entry_tag_reg[j] <= entry_tag_reg[(j > 0) ? j - 1 : 0];
                end else if (CNT_W'(j) == pos_reg) begin
                    entry_seq_reg[j] <= seq_in_reg;
                    entry_len_reg[j] <= len_in_reg;
                    entry_tag_reg[j] <= tag_in_reg;
                end
            end else if (cmd.pop && j < MAX_SEGMENTS - 1) begin
                entry_seq_reg[j] <= entry_seq_reg[(j < MAX_SEGMENTS - 1) ? j + 1 : j];
                entry_len_reg[j] <= entry_len_reg[(j < MAX_SEGMENTS - 1) ? j + 1 : j];
                entry_tag_reg[j] <= entry_tag_reg[(j < MAX_SEGMENTS - 1) ? j + 1 : j];
            end
        end
        if (cmd.emit) begin
            m_event_reg <= cmd.ev;
            m_acc_reg   <= cmd.acc;
            m_last_reg  <= cmd.last;
            m_dis_reg   <= !enabled_reg;
            m_tag_reg   <= 8'd0;
            m_seq_reg   <= 32'd0;
            m_next_reg  <= 32'd0;
            if (cmd.ev == EV_DELIVER || cmd.ev == EV_DROP) begin
                m_tag_reg <= tag_wide_out[7:0];
                m_seq_reg <= entry_seq_reg[0];
            end
            if (cmd.ev == EV_DONE) m_next_reg <= nxt_reg;
        end
    end

    always_comb begin
        stat              = '0;
        stat.in_action    = s_action;
        stat.out_free     = out_free;
        stat.count_zero   = (count_reg == '0);
        stat.count_one    = (count_reg == CNT_W'(1));
        stat.enabled      = enabled_reg;
        stat.reject       = reject_reg;
        stat.hit_eq       = hit_eq_reg;
        stat.len_mismatch = (len_in_reg != sel_len_reg);
        stat.overlap      = hit_lt_reg && !((seg_end == sel_seq_reg) || end_diff[31]);
        stat.head_match   = (entry_seq_reg[0] == nxt_reg);
    end

    assign m_valid          = m_valid_reg;
    assign m_event_res      = m_event_reg;
    assign m_accepted       = m_acc_reg;
    assign m_out_tag        = m_tag_reg;
    assign m_out_seq        = m_seq_reg;
    assign m_next_seq       = m_next_reg;
    assign m_queue_disabled = m_dis_reg;
    assign m_last           = m_last_reg;

    `TSRQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(MAX_SEGMENTS))
    `TSRQ_ASSERT_IMPLY(a_emit_free, cmd.emit, out_free)
    `TSRQ_ASSERT_IMPLY(a_ins_room, cmd.ins, enabled_reg && count_reg < CNT_W'(MAX_SEGMENTS))
    `TSRQ_ASSERT_NEXT(a_dis_sticky, !enabled_reg, !enabled_reg)

endmodule
